FILE: rtl/line_follow_pd_steering_macros.svh
// Assertion macros for the line follower PD steering block.
`ifndef LINE_FOLLOW_PD_STEERING_MACROS_SVH
`define LINE_FOLLOW_PD_STEERING_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LFPD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfpd assertion failed");
// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LFPD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfpd assertion failed");
`else
`define LFPD_ASSERT_IMP(lbl, ante, cons)
`define LFPD_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/lfpd_pkg.sv
// Package: microcode, constants, gain tables and helpers for the PD steering block.
`timescale 1ns / 1ps
`default_nettype none

package lfpd_pkg;

    // Gain table depth and configuration register indexes
    localparam int GAIN_TABLE_DEPTH = 8;

    localparam logic [2:0] CFG_BASE_SPEED   = 3'd0;
    localparam logic [2:0] CFG_SEARCH_SPEED = 3'd1;
    localparam logic [2:0] CFG_SEARCH_GAIN  = 3'd2;
    localparam logic [2:0] CFG_SEARCH_CAP   = 3'd3;
    localparam logic [2:0] CFG_SLEW_LIMIT   = 3'd4;

    localparam logic [13:0] BASE_SPEED_RST   = 14'd11469;
    localparam logic [13:0] SEARCH_SPEED_RST = 14'd4915;
    localparam logic [11:0] SEARCH_GAIN_RST  = 12'd1245;
    localparam logic [2:0]  SEARCH_CAP_RST   = 3'd6;
    localparam logic [3:0]  SLEW_LIMIT_RST   = 4'd5;

    // Result modes
    localparam logic [1:0] MODE_TRACK         = 2'd0;
    localparam logic [1:0] MODE_CROSSING      = 2'd1;
    localparam logic [1:0] MODE_SEARCH        = 2'd2;
    localparam logic [1:0] MODE_LOST_STRAIGHT = 2'd3;

    // Sensor weights, left to right
    localparam logic signed [4:0] SENSOR_WEIGHT [0:7] = '{
        -5'sd7, -5'sd5, -5'sd3, -5'sd1, 5'sd1, 5'sd3, 5'sd5, 5'sd7
    };

    // PD gains, Q1.15, indexed by filtered error magnitude
    localparam logic [9:0] KP_ROM [0:GAIN_TABLE_DEPTH-1] = '{
        10'd262, 10'd393, 10'd590, 10'd590, 10'd668, 10'd613, 10'd557, 10'd498
    };
    localparam logic [7:0] KD_ROM [0:GAIN_TABLE_DEPTH-1] = '{
        8'd154, 8'd193, 8'd246, 8'd246, 8'd210, 8'd193, 8'd246, 8'd246
    };

    // Datapath operations
    localparam logic [3:0] OP_NOP        = 4'd0;
    localparam logic [3:0] OP_LOAD       = 4'd1;
    localparam logic [3:0] OP_SUM        = 4'd2;
    localparam logic [3:0] OP_DIV        = 4'd3;
    localparam logic [3:0] OP_SLEW       = 4'd4;
    localparam logic [3:0] OP_PTERM      = 4'd5;
    localparam logic [3:0] OP_DTERM      = 4'd6;
    localparam logic [3:0] OP_FIN_TRACK  = 4'd7;
    localparam logic [3:0] OP_CROSS      = 4'd8;
    localparam logic [3:0] OP_LOST_MUL   = 4'd9;
    localparam logic [3:0] OP_FIN_SEARCH = 4'd10;
    localparam logic [3:0] OP_EMIT       = 4'd11;

    // Jump conditions
    localparam logic [2:0] JC_NEVER    = 3'd0;
    localparam logic [2:0] JC_ALWAYS   = 3'd1;
    localparam logic [2:0] JC_NO_INPUT = 3'd2;
    localparam logic [2:0] JC_ALL_SET  = 3'd3;
    localparam logic [2:0] JC_NONE_SET = 3'd4;
    localparam logic [2:0] JC_DIV_MORE = 3'd5;
    localparam logic [2:0] JC_OUT_BUSY = 3'd6;

    // Step addresses
    localparam logic [3:0] STEP_IDLE       = 4'd0;
    localparam logic [3:0] STEP_SUM        = 4'd1;
    localparam logic [3:0] STEP_EMPTY      = 4'd2;
    localparam logic [3:0] STEP_DIV        = 4'd3;
    localparam logic [3:0] STEP_SLEW       = 4'd4;
    localparam logic [3:0] STEP_PTERM      = 4'd5;
    localparam logic [3:0] STEP_DTERM      = 4'd6;
    localparam logic [3:0] STEP_FIN_TRACK  = 4'd7;
    localparam logic [3:0] STEP_CROSS      = 4'd8;
    localparam logic [3:0] STEP_LOST       = 4'd9;
    localparam logic [3:0] STEP_FIN_SEARCH = 4'd10;
    localparam logic [3:0] STEP_EMIT       = 4'd15;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] cond;
        logic [3:0] target;
    } ctrl_word_t;

    // Microprogram; a step that does not jump falls through to the next address
    function automatic ctrl_word_t ucode_rom(input logic [3:0] addr);
        ctrl_word_t w;
        unique case (addr)
            STEP_IDLE:       w = '{op: OP_LOAD,       cond: JC_NO_INPUT, target: STEP_IDLE};
            STEP_SUM:        w = '{op: OP_SUM,        cond: JC_ALL_SET,  target: STEP_CROSS};
            STEP_EMPTY:      w = '{op: OP_NOP,        cond: JC_NONE_SET, target: STEP_LOST};
            STEP_DIV:        w = '{op: OP_DIV,        cond: JC_DIV_MORE, target: STEP_DIV};
            STEP_SLEW:       w = '{op: OP_SLEW,       cond: JC_NEVER,    target: STEP_IDLE};
            STEP_PTERM:      w = '{op: OP_PTERM,      cond: JC_NEVER,    target: STEP_IDLE};
            STEP_DTERM:      w = '{op: OP_DTERM,      cond: JC_NEVER,    target: STEP_IDLE};
            STEP_FIN_TRACK:  w = '{op: OP_FIN_TRACK,  cond: JC_ALWAYS,   target: STEP_EMIT};
            STEP_CROSS:      w = '{op: OP_CROSS,      cond: JC_ALWAYS,   target: STEP_EMIT};
            STEP_LOST:       w = '{op: OP_LOST_MUL,   cond: JC_NEVER,    target: STEP_IDLE};
            STEP_FIN_SEARCH: w = '{op: OP_FIN_SEARCH, cond: JC_ALWAYS,   target: STEP_EMIT};
            STEP_EMIT:       w = '{op: OP_EMIT,       cond: JC_OUT_BUSY, target: STEP_EMIT};
            default:         w = '{op: OP_NOP,        cond: JC_ALWAYS,   target: STEP_IDLE};
        endcase
        return w;
    endfunction

    // Saturate to signed 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -18'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/line_follow_pd_steering.sv
// Line follower PD steering: microcoded sequencer, datapath and result register.
//
//   channel   dir   handshake              payload
//   in        in    in_valid / in_stall    sensor_bits
//   out       out   out_valid / out_stall  left_speed, right_speed, line_error,
//                                          last_valid_error, line_lost, mode
//   cfg       in    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One word at a time runs through the microprogram. While tracking it sums the sensors,
// runs the quotient loop, slew-limits the error, forms the P and D terms and builds the
// result; when the line is lost it forms the search product first; at a crossing it builds
// the result at once. The emit step loads the result register; the next word is taken in idle.
// Reset clears the sequencer, the result valid and the error state, and presets the configuration registers.
// A stalled result holds the sequencer in its emit step until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module line_follow_pd_steering (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         sensor_bits,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [15:0]      left_speed,
    output logic signed [15:0]      right_speed,
    output logic signed [3:0]       line_error,
    output logic signed [3:0]       last_valid_error,
    output logic                    line_lost,
    output logic [1:0]              mode,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [13:0]        cfg_data
);
    import lfpd_pkg::*;

`include "line_follow_pd_steering_macros.svh"

    // Sequencer
    logic [3:0]  pc_reg;
    logic [3:0]  pc_next;
    ctrl_word_t  cw;
    logic        jump;

    // Configuration
    logic [13:0] base_speed_reg;
    logic [13:0] search_speed_reg;
    logic [11:0] search_gain_reg;
    logic [2:0]  search_cap_reg;
    logic [3:0]  slew_limit_reg;

    // Error state
    logic signed [3:0] previous_reg;
    logic signed [3:0] remembered_reg;
    logic signed [3:0] smoothed_reg;

    // Datapath
    logic [7:0]         bits_reg;
    logic               wsum_neg_reg;
    logic [4:0]         rem_reg;
    logic [2:0]         count_reg;
    logic [2:0]         quo_reg;
    logic [1:0]         div_k_reg;
    logic signed [3:0]  lerr_reg;
    logic [2:0]         idx_reg;
    logic signed [4:0]  deriv_reg;
    logic signed [17:0] acc_reg;

    // Staged result
    logic signed [15:0] res_left_reg;
    logic signed [15:0] res_right_reg;
    logic signed [3:0]  res_lerr_reg;
    logic               res_lost_reg;
    logic [1:0]         res_mode_reg;

    // Result register
    logic               out_valid_reg;
    logic               out_valid_next;
    logic signed [15:0] left_reg;
    logic signed [15:0] right_reg;
    logic signed [3:0]  lerr_out_reg;
    logic signed [3:0]  last_err_reg;
    logic               lost_reg;
    logic [1:0]         mode_reg;

    logic in_fire;
    logic emit_fire;

    // Combinational datapath terms
    logic signed [5:0]  wsum_c;
    logic signed [5:0]  wsum_neg_c;
    logic [3:0]         cnt_c;
    logic [5:0]         div_sh_c;
    logic [5:0]         rem_ext_c;
    logic [5:0]         rem_sub_c;
    logic signed [3:0]  quo_s_c;
    logic signed [3:0]  lerr_c;
    logic signed [5:0]  delta_c;
    logic signed [5:0]  lim_c;
    logic signed [5:0]  delta_lim_c;
    logic signed [3:0]  smooth_neg_c;
    logic [2:0]         idx_c;
    logic signed [4:0]  deriv_c;
    logic signed [17:0] pterm_c;
    logic signed [17:0] dterm_c;
    logic signed [17:0] base_c;
    logic signed [17:0] corr_c;
    logic signed [3:0]  remem_neg_c;
    logic [2:0]         remem_abs_c;
    logic [2:0]         capped_c;
    logic [14:0]        sprod_c;
    logic signed [17:0] search_c;

    // Ports
    assign in_stall         = (pc_reg != STEP_IDLE);
    assign cfg_ready        = 1'b1;
    assign out_valid        = out_valid_reg;
    assign left_speed       = left_reg;
    assign right_speed      = right_reg;
    assign line_error       = lerr_out_reg;
    assign last_valid_error = last_err_reg;
    assign line_lost        = lost_reg;
    assign mode             = mode_reg;

    // Fetch the control word and pick the next step
    assign cw        = ucode_rom(pc_reg);
    assign in_fire   = (pc_reg == STEP_IDLE) && in_valid;
    assign emit_fire = (cw.op == OP_EMIT) && !(out_valid_reg && out_stall);

    always_comb
    begin
        unique case (cw.cond)
            JC_NEVER:    jump = 1'b0;
            JC_ALWAYS:   jump = 1'b1;
            JC_NO_INPUT: jump = !in_valid;
            JC_ALL_SET:  jump = (cnt_c == 4'd8);
            JC_NONE_SET: jump = (cnt_c == 4'd0);
            JC_DIV_MORE: jump = (div_k_reg != 2'd0);
            JC_OUT_BUSY: jump = out_valid_reg && out_stall;
            default:     jump = 1'b0;
        endcase
        pc_next = jump ? cw.target : 4'(pc_reg + 4'd1);
    end

    // Weighted sum and hit count of the sensors
    always_comb
    begin
        wsum_c = '0;
        cnt_c  = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (bits_reg[i])
            begin
                wsum_c = wsum_c + $signed({SENSOR_WEIGHT[i][4], SENSOR_WEIGHT[i]});
                cnt_c  = cnt_c + {3'b000, bits_reg[i]};
            end
        end
        wsum_neg_c = -wsum_c;
    end

    // One quotient bit per step
    assign div_sh_c  = {3'b000, count_reg} << div_k_reg;
    assign rem_ext_c = {1'b0, rem_reg};
    assign rem_sub_c = rem_ext_c - div_sh_c;

    // Signed raw error and slew limit
    always_comb
    begin
        quo_s_c = $signed({1'b0, quo_reg});
        lerr_c  = wsum_neg_reg ? -quo_s_c : quo_s_c;
        delta_c = $signed({{2{lerr_c[3]}}, lerr_c}) -
                  $signed({{2{smoothed_reg[3]}}, smoothed_reg});
        lim_c   = $signed({2'b00, slew_limit_reg});
        if (delta_c > lim_c) begin
            delta_lim_c = lim_c;
        end else if (delta_c < -lim_c) begin
            delta_lim_c = -lim_c;
        end else begin
            delta_lim_c = delta_c;
        end
    end

    // Gain index, derivative and the two PD products
    always_comb
    begin
        smooth_neg_c = -smoothed_reg;
        idx_c        = smoothed_reg[3] ? smooth_neg_c[2:0] : smoothed_reg[2:0];
        deriv_c      = $signed({smoothed_reg[3], smoothed_reg}) -
                       $signed({previous_reg[3], previous_reg});
        pterm_c      = $signed({8'b0, KP_ROM[idx_c]}) *
                       $signed({{14{smoothed_reg[3]}}, smoothed_reg});
        dterm_c      = $signed({10'b0, KD_ROM[idx_reg]}) *
                       $signed({{13{deriv_reg[4]}}, deriv_reg});
    end

    // Clamp the tracking correction to the base speed
    always_comb
    begin
        base_c = $signed({4'b0000, base_speed_reg});
        if (acc_reg > base_c) begin
            corr_c = base_c;
        end else if (acc_reg < -base_c) begin
            corr_c = -base_c;
        end else begin
            corr_c = acc_reg;
        end
    end

    // Search correction from the remembered error
    always_comb
    begin
        remem_neg_c = -remembered_reg;
        remem_abs_c = remembered_reg[3] ? remem_neg_c[2:0] : remembered_reg[2:0];
        capped_c    = (remem_abs_c > search_cap_reg) ? search_cap_reg : remem_abs_c;
        sprod_c     = {3'b000, search_gain_reg} * {12'b0, capped_c};
        search_c    = $signed({4'b0000, search_speed_reg});
    end

    // Sequencer, configuration and error state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg           <= STEP_IDLE;
            base_speed_reg   <= BASE_SPEED_RST;
            search_speed_reg <= SEARCH_SPEED_RST;
            search_gain_reg  <= SEARCH_GAIN_RST;
            search_cap_reg   <= SEARCH_CAP_RST;
            slew_limit_reg   <= SLEW_LIMIT_RST;
            previous_reg     <= '0;
            remembered_reg   <= '0;
            smoothed_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;

            // Take configuration writes; unknown indexes drop
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_BASE_SPEED:   base_speed_reg   <= cfg_data;
                    CFG_SEARCH_SPEED: search_speed_reg <= cfg_data;
                    CFG_SEARCH_GAIN:  search_gain_reg  <= cfg_data[11:0];
                    CFG_SEARCH_CAP:   search_cap_reg   <= cfg_data[2:0];
                    CFG_SLEW_LIMIT:   slew_limit_reg   <= cfg_data[3:0];
                    default:          ;
                endcase
            end

            // Advance the error state on tracking ticks only
            if (cw.op == OP_SLEW)
            begin
                remembered_reg <= lerr_c;
                smoothed_reg   <= smoothed_reg + $signed(delta_lim_c[3:0]);
            end
            if (cw.op == OP_PTERM)
            begin
                previous_reg <= smoothed_reg;
            end
        end
    end

    // Result valid: set on emit, drop when taken
    always_comb
    begin
        if (emit_fire) begin
            out_valid_next = 1'b1;
        end else if (out_valid_reg && !out_stall) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Datapath registers, driven by the current operation
    always_ff @(posedge clk)
    begin
        unique case (cw.op)
            OP_LOAD:
            begin
                if (in_fire) begin
                    bits_reg <= sensor_bits;
                end
            end
            OP_SUM:
            begin
                wsum_neg_reg <= wsum_c[5];
                rem_reg      <= wsum_c[5] ? wsum_neg_c[4:0] : wsum_c[4:0];
                count_reg    <= cnt_c[2:0];
                quo_reg      <= '0;
                div_k_reg    <= 2'd2;
            end
            OP_DIV:
            begin
                if (rem_ext_c >= div_sh_c)
                begin
                    rem_reg            <= rem_sub_c[4:0];
                    quo_reg[div_k_reg] <= 1'b1;
                end
                div_k_reg <= div_k_reg - 2'd1;
            end
            OP_SLEW:
            begin
                lerr_reg <= lerr_c;
            end
            OP_PTERM:
            begin
                idx_reg   <= idx_c;
                deriv_reg <= deriv_c;
                acc_reg   <= pterm_c;
            end
            OP_DTERM:
            begin
                acc_reg <= acc_reg + dterm_c;
            end
            OP_FIN_TRACK:
            begin
                res_left_reg  <= sat16(base_c + corr_c);
                res_right_reg <= sat16(base_c - corr_c);
                res_lerr_reg  <= lerr_reg;
                res_lost_reg  <= 1'b0;
                res_mode_reg  <= MODE_TRACK;
            end
            OP_CROSS:
            begin
                res_left_reg  <= base_c[15:0];
                res_right_reg <= base_c[15:0];
                res_lerr_reg  <= '0;
                res_lost_reg  <= 1'b0;
                res_mode_reg  <= MODE_CROSSING;
            end
            OP_LOST_MUL:
            begin
                acc_reg <= remembered_reg[3] ? -$signed({3'b000, sprod_c})
                                             : $signed({3'b000, sprod_c});
            end
            OP_FIN_SEARCH:
            begin
                res_lerr_reg <= '0;
                res_lost_reg <= 1'b1;
                if (remembered_reg == 4'sd0)
                begin
                    res_left_reg  <= base_c[15:0];
                    res_right_reg <= base_c[15:0];
                    res_mode_reg  <= MODE_LOST_STRAIGHT;
                end
                else
                begin
                    res_left_reg  <= sat16(search_c + acc_reg);
                    res_right_reg <= sat16(search_c - acc_reg);
                    res_mode_reg  <= MODE_SEARCH;
                end
            end
            OP_EMIT:
            begin
                if (emit_fire)
                begin
                    left_reg     <= res_left_reg;
                    right_reg    <= res_right_reg;
                    lerr_out_reg <= res_lerr_reg;
                    last_err_reg <= remembered_reg;
                    lost_reg     <= res_lost_reg;
                    mode_reg     <= res_mode_reg;
                end
            end
            default: ;
        endcase
    end

    // Checks
    `LFPD_ASSERT_IMP(a_lost_matches_mode, out_valid_reg, (lost_reg == ((mode_reg == MODE_SEARCH) || (mode_reg == MODE_LOST_STRAIGHT))))
    `LFPD_ASSERT_IMP(a_err_zero_off_track, (out_valid_reg && (mode_reg != MODE_TRACK)), (lerr_out_reg == 4'sd0))
    `LFPD_ASSERT_IMP(a_smoothed_in_range, 1'b1, (smoothed_reg != -4'sd8))
    `LFPD_ASSERT_NXT(a_emit_returns_idle, ((pc_reg == STEP_EMIT) && !(out_valid_reg && out_stall)), (out_valid_reg && (pc_reg == STEP_IDLE)))

endmodule

`default_nettype wire

FILE: sim/line_follow_pd_steering_checker.sv
// Scoreboard for the PD steering block: mirrors the registers, predicts each result word and checks it.
`timescale 1ns / 1ps

module line_follow_pd_steering_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [7:0]         sensor_bits,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [15:0] left_speed,
    input  logic signed [15:0] right_speed,
    input  logic signed [3:0]  line_error,
    input  logic signed [3:0]  last_valid_error,
    input  logic               line_lost,
    input  logic [1:0]         mode,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [13:0]        cfg_data,
    output int                 mismatch_count,
    output int                 pending_count
);
    import lfpd_pkg::*;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic signed [3:0]  line_err;
        logic signed [3:0]  held_err;
        logic               lost;
        logic [1:0]         mode;
    } wheel_cmd_t;

    // PD gains in Q1.15, indexed by filtered error magnitude
    localparam int KP_GAIN [0:7] = '{262, 393, 590, 590, 668, 613, 557, 498};
    localparam int KD_GAIN [0:7] = '{154, 193, 246, 246, 210, 193, 246, 246};
    localparam int REPORT_LIMIT = 10;

    logic [13:0]       base_speed_q;
    logic [13:0]       search_speed_q;
    logic [11:0]       search_gain_q;
    logic [2:0]        search_cap_q;
    logic [3:0]        slew_limit_q;
    logic signed [3:0] prev_err_q;
    logic signed [3:0] held_err_q;
    logic signed [3:0] smooth_err_q;
    wheel_cmd_t        pending_cmds [$];
    int                reported;

    function automatic logic signed [15:0] clip_q15(input int v);
        int r;
        r = v;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    // Advance the steering state by one tick and return the wheel command it gives
    function automatic wheel_cmd_t steer_tick(input logic [7:0] bits);
        wheel_cmd_t c;
        int i, wsum, hits, raw, step, lim, err, mag, idx, deriv, corr, base, cruise, gain;
        wsum = 0;
        hits = 0;
        base = base_speed_q;
        for (i = 0; i < 8; i++) begin
            if (bits[i]) begin
                wsum += 2 * i - 7;
                hits++;
            end
        end
        c.line_err = '0;
        c.lost = 1'b0;
        if (hits == 8) begin
            // crossing: straight ahead, state untouched
            c.left = base[15:0];
            c.right = base[15:0];
            c.mode = MODE_CROSSING;
        end else if (hits == 0) begin
            c.lost = 1'b1;
            err = held_err_q;
            if (err != 0) begin
                // turn toward the side the line was last seen on
                mag = err < 0 ? -err : err;
                lim = search_cap_q;
                if (mag > lim) mag = lim;
                gain = search_gain_q;
                cruise = search_speed_q;
                corr = gain * mag;
                if (err < 0) corr = -corr;
                c.left = clip_q15(cruise + corr);
                c.right = clip_q15(cruise - corr);
                c.mode = MODE_SEARCH;
            end else begin
                c.left = base[15:0];
                c.right = base[15:0];
                c.mode = MODE_LOST_STRAIGHT;
            end
        end else begin
            raw = wsum / hits;
            held_err_q = raw[3:0];
            // slew-limit the filtered error toward the raw one
            err = smooth_err_q;
            lim = slew_limit_q;
            step = raw - err;
            if (step > lim) step = lim;
            if (step < -lim) step = -lim;
            err = err + step;
            smooth_err_q = err[3:0];
            mag = err < 0 ? -err : err;
            idx = mag < 8 ? mag : 7;
            deriv = err - prev_err_q;
            prev_err_q = err[3:0];
            corr = KP_GAIN[idx] * err + KD_GAIN[idx] * deriv;
            if (corr > base) corr = base;
            if (corr < -base) corr = -base;
            c.left = clip_q15(base + corr);
            c.right = clip_q15(base - corr);
            c.line_err = raw[3:0];
            c.mode = MODE_TRACK;
        end
        c.held_err = held_err_q;
        return c;
    endfunction

    always @(posedge clk or negedge rst_n) begin : score
        wheel_cmd_t seen;
        wheel_cmd_t want;
        logic       bad;
        if (!rst_n) begin
            base_speed_q = BASE_SPEED_RST;
            search_speed_q = SEARCH_SPEED_RST;
            search_gain_q = SEARCH_GAIN_RST;
            search_cap_q = SEARCH_CAP_RST;
            slew_limit_q = SLEW_LIMIT_RST;
            prev_err_q = '0;
            held_err_q = '0;
            smooth_err_q = '0;
            pending_cmds.delete();
            mismatch_count = 0;
            pending_count = 0;
            reported = 0;
        end else begin
            // mirror register writes; unused indexes drop
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_BASE_SPEED:   base_speed_q = cfg_data;
                    CFG_SEARCH_SPEED: search_speed_q = cfg_data;
                    CFG_SEARCH_GAIN:  search_gain_q = cfg_data[11:0];
                    CFG_SEARCH_CAP:   search_cap_q = cfg_data[2:0];
                    CFG_SLEW_LIMIT:   slew_limit_q = cfg_data[3:0];
                    default: ;
                endcase
            end
            // compare an accepted result word with the oldest prediction
            if (out_valid && !out_stall) begin
                seen.left = left_speed;
                seen.right = right_speed;
                seen.line_err = line_error;
                seen.held_err = last_valid_error;
                seen.lost = line_lost;
                seen.mode = mode;
                if (pending_cmds.size() == 0) begin
                    mismatch_count++;
                    if (reported < REPORT_LIMIT) begin
                        reported++;
                        $display("%0t: result word with none expected: L=%0d R=%0d mode=%0d",
                                 $realtime, seen.left, seen.right, seen.mode);
                    end
                end else begin
                    want = pending_cmds.pop_front();
                    bad = (seen.left !== want.left) || (seen.right !== want.right)
                        || (seen.line_err !== want.line_err)
                        || (seen.held_err !== want.held_err)
                        || (seen.lost !== want.lost) || (seen.mode !== want.mode);
                    if (bad) begin
                        mismatch_count++;
                        if (reported < REPORT_LIMIT) begin
                            reported++;
                            $display("%0t: mismatch exp L=%0d R=%0d err=%0d held=%0d lost=%0b mode=%0d",
                                     $realtime, want.left, want.right, want.line_err,
                                     want.held_err, want.lost, want.mode);
                            $display("%0t:          got L=%0d R=%0d err=%0d held=%0d lost=%0b mode=%0d",
                                     $realtime, seen.left, seen.right, seen.line_err,
                                     seen.held_err, seen.lost, seen.mode);
                        end
                    end
                end
            end
            // predict the word an accepted sensor sample will give
            if (in_valid && !in_stall) begin
                pending_cmds.push_back(steer_tick(sensor_bits));
            end
            pending_count = pending_cmds.size();
        end
    end

endmodule

FILE: sim/line_follow_pd_steering_tb.sv
// Testbench top for the PD steering block: clock, reset, stimulus, register setup and verdict.
`timescale 1ns / 1ps

module line_follow_pd_steering_tb;
    import lfpd_pkg::*;

    localparam int LONG_HOLD     = 400;
    localparam int IDLE_LIMIT    = 5000;
    localparam int SETTLE_CYCLES = 40;
    localparam logic [2:0] CFG_UNUSED_LOW  = 3'd5;
    localparam logic [2:0] CFG_UNUSED_HIGH = 3'd7;
    localparam int DIRECTED_LEN = 24;
    // edges, crossing, both lost cases, truncation of uneven splits, big slew jumps
    localparam logic [7:0] DIRECTED [0:DIRECTED_LEN-1] = '{
        8'h00, 8'h01, 8'h80, 8'h00, 8'hFF, 8'h18, 8'h00, 8'h03,
        8'h07, 8'h0F, 8'h0B, 8'hD0, 8'h7F, 8'hFE, 8'h81, 8'h55,
        8'hAA, 8'h10, 8'h08, 8'h01, 8'h00, 8'h06, 8'h05, 8'hE0
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic [7:0]         sensor_bits = '0;
    logic               out_stall = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [13:0]        cfg_data = '0;
    logic               in_stall;
    logic               out_valid;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic signed [3:0]  line_error;
    logic signed [3:0]  last_valid_error;
    logic               line_lost;
    logic [1:0]         mode;
    logic               cfg_ready;
    int                 mismatch_count;
    int                 pending_count;
    bit                 hold_req = 1'b0;
    bit                 calm = 1'b0;
    int                 line_pos = 3;

    line_follow_pd_steering dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .sensor_bits      (sensor_bits),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .left_speed       (left_speed),
        .right_speed      (right_speed),
        .line_error       (line_error),
        .last_valid_error (last_valid_error),
        .line_lost        (line_lost),
        .mode             (mode),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    line_follow_pd_steering_checker steer_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .sensor_bits      (sensor_bits),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .left_speed       (left_speed),
        .right_speed      (right_speed),
        .line_error       (line_error),
        .last_valid_error (last_valid_error),
        .line_lost        (line_lost),
        .mode             (mode),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatch_count   (mismatch_count),
        .pending_count    (pending_count)
    );

    initial begin : clock_gen
        forever #2 clk = ~clk;
    end

    // Stall the result side in runs: mostly short, a few long, none while calm
    initial begin : out_pacer
        int len;
        int r;
        @(negedge clk);
        forever begin
            r = $urandom_range(0, 99);
            if (hold_req) begin
                out_stall <= 1'b1;
                len = LONG_HOLD;
                hold_req = 1'b0;
            end else if (calm || r < 55) begin
                out_stall <= 1'b0;
                len = $urandom_range(1, 8);
            end else if (r < 90) begin
                out_stall <= 1'b1;
                len = $urandom_range(1, 3);
            end else if (r < 97) begin
                out_stall <= 1'b1;
                len = $urandom_range(4, 12);
            end else begin
                out_stall <= 1'b1;
                len = $urandom_range(20, 60);
            end
            repeat (len) @(negedge clk);
        end
    end

    // End the run when nothing moves on any channel for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("simulation failed");
        $finish;
    end

    // Offer one sensor word after a random gap and hold it until taken
    task automatic send_word(input logic [7:0] bits);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) gap = 0;
        else if (r < 85) gap = $urandom_range(1, 3);
        else if (r < 97) gap = $urandom_range(4, 10);
        else gap = $urandom_range(20, 50);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        sensor_bits <= bits;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    // Drop valid and wait until every predicted word has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [13:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic program_regs(input logic [13:0] base, input logic [13:0] cruise,
                                input logic [13:0] gain, input logic [13:0] cap,
                                input logic [13:0] slew);
        write_reg(CFG_BASE_SPEED, base);
        write_reg(CFG_SEARCH_SPEED, cruise);
        write_reg(CFG_SEARCH_GAIN, gain);
        write_reg(CFG_SEARCH_CAP, cap);
        write_reg(CFG_SLEW_LIMIT, slew);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Mostly a narrow line drifting across the array, with lost, crossing and noise words
    function automatic logic [7:0] next_pattern();
        int r;
        int step;
        int width;
        logic [15:0] run;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            if ($urandom_range(0, 9) == 0) begin
                line_pos = $urandom_range(0, 7);
            end else begin
                step = $urandom_range(0, 2);
                line_pos = line_pos + step - 1;
            end
            if (line_pos < 0) line_pos = 0;
            if (line_pos > 7) line_pos = 7;
            width = $urandom_range(1, 3);
            run = ((16'd1 << width) - 16'd1) << line_pos;
            return run[7:0];
        end else if (r < 75) begin
            return 8'h00;
        end else if (r < 80) begin
            return 8'hFF;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic run_random(input int count);
        int n;
        for (n = 0; n < count; n++) send_word(next_pattern());
    endtask

    initial begin : stimulus
        int i;
        int p;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: directed words, then a long result hold and a full pause
        for (i = 0; i < DIRECTED_LEN; i++) send_word(DIRECTED[i]);
        run_random(120);
        hold_req = 1'b1;
        run_random(80);
        drain();
        run_random(100);
        drain();

        // all-ones data: widest speeds and gains, slew acts as no limit
        program_regs(14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF);
        calm = 1'b1;
        run_random(100);
        calm = 1'b0;
        run_random(150);
        drain();

        // all zero: filtered error frozen, zero search correction
        program_regs(14'd0, 14'd0, 14'd0, 14'd0, 14'd0);
        run_random(120);
        drain();

        // full speed, zero cap, slowest nonzero slew
        program_regs(14'h3FFF, 14'd0, 14'd4095, 14'd0, 14'd1);
        run_random(120);
        drain();

        // random settings, each with a write to an unused index
        for (p = 0; p < 5; p++) begin
            write_reg(3'($urandom_range(CFG_UNUSED_LOW, CFG_UNUSED_HIGH)),
                      14'($urandom_range(0, 16383)));
            program_regs(14'($urandom_range(0, 16383)), 14'($urandom_range(0, 16383)),
                         14'($urandom_range(0, 16383)), 14'($urandom_range(0, 16383)),
                         14'($urandom_range(0, 16383)));
            run_random(180);
            drain();
        end

        if (mismatch_count == 0 && pending_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
